/* sv/alid_pkg.sv */
// Package: list geometry, operation and status codes.
package alid_pkg;
	localparam int DEPTH = 64;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = 32;

	localparam logic [2:0] K_INS_HEAD = 3'd0;
	localparam logic [2:0] K_INS_TAIL = 3'd1;
	localparam logic [2:0] K_INS_POS  = 3'd2;
	localparam logic [2:0] K_DEL_HEAD = 3'd3;
	localparam logic [2:0] K_DEL_TAIL = 3'd4;
	localparam logic [2:0] K_DEL_VAL  = 3'd5;
	localparam logic [2:0] K_CLEAR    = 3'd6;
	localparam logic [2:0] K_NOP      = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;
endpackage

/* sv/alid_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module alid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* sv/array_list_insert_delete_top.sv */
// Top level: ordered list of signed words kept in one RAM with a count.
// Operations: clear, full, empty, unused kind and delete tail of one entry finish
//   without RAM access; delete tail reads the new last entry without a shift;
//   delete head and insert move entries, each read and then written; delete value
//   reads every entry and writes back those that do not match.
// Items are handled one at a time; the next item is accepted in the cycle after
//   the result is accepted, once the FSM is back in S_IDLE.
// Reset: count clears; RAM contents are not cleared, slots at or past the
//   count are never read, so no clearing pass is needed.
// last_value is tracked in a register, so results need no extra RAM read.
module array_list_insert_delete_top
	import alid_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [31:0] value,
	input  logic [6:0]         position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [6:0]         count,
	output logic signed [31:0] last_value,
	output logic [1:0]         status
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INS  = 5'b00010,   // shift up, walking down from the top
		S_DEL  = 5'b00100,   // shift down from a fixed index
		S_CMP  = 5'b01000,   // compaction scan for delete value
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [CW-1:0] used_q;
	logic [CW:0] rd_q, wr_q;   // read and write cursors
	logic rvalid_q;           // a read issued last cycle
	logic [DW-1:0] val_q, last_q;
	logic [AW-1:0] ins_idx_q;
	logic [1:0] st_q;
	logic [CW-1:0] cnt_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata;

	alid_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic busy_out;
	assign busy_out = out_valid && !out_ready;
	assign in_ready = (state_q == S_IDLE) && !busy_out;
	assign out_valid = (state_q == S_OUT);
	assign count = 7'(cnt_q);
	assign last_value = (cnt_q == '0) ? '0 : last_q;
	assign status = st_q;

	// read address = read cursor; moved data is written when it returns
	assign raddr = rd_q[AW-1:0];

	always_comb begin
		we = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			S_INS: begin
				if (rvalid_q) we = 1'b1;
				else if (rd_q[CW] || rd_q[CW-1:0] < CW'(ins_idx_q) || rd_q == '1) begin
					we = 1'b1;
					wdata = val_q;
				end
			end
			S_DEL: we = rvalid_q;
			S_CMP: we = rvalid_q && (rdata != val_q);
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			cnt_q <= '0;
			rvalid_q <= 1'b0;
			st_q <= ST_OK;
			rd_q <= '0;
			wr_q <= '0;
			val_q <= '0;
			last_q <= '0;
			ins_idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rvalid_q <= 1'b0;
					if (in_valid && in_ready) begin
						val_q <= value;
						st_q <= ST_OK;
						state_q <= S_OUT;
						cnt_q <= used_q;
						if (kind inside {K_INS_HEAD, K_INS_TAIL, K_INS_POS}) begin
							if (used_q == CW'(DEPTH)) st_q <= ST_FULL;
							else begin
								if (kind == K_INS_HEAD || (kind == K_INS_POS && position == '0))
									ins_idx_q <= '0;
								else if (kind == K_INS_TAIL || CW'(position) > used_q
									|| position > 7'(DEPTH))
									ins_idx_q <= AW'(used_q);
								else ins_idx_q <= AW'(position - 7'd1);
								// read used-1 first; wr cursor = used
								rd_q <= (CW+1)'(used_q) - 1'b1;
								wr_q <= (CW+1)'(used_q);
								state_q <= S_INS;
							end
						end else if (kind inside {K_DEL_HEAD, K_DEL_TAIL, K_DEL_VAL}) begin
							if (used_q == '0) st_q <= ST_EMPTY;
							else if (kind == K_DEL_TAIL) begin
								used_q <= used_q - 1'b1;
								cnt_q <= used_q - 1'b1;
								if (used_q == CW'(1)) state_q <= S_OUT;
								else begin
									rd_q <= (CW+1)'(used_q) - 2'd2;
									wr_q <= '1;  // no shift; fetch new last
									state_q <= S_DEL;
								end
							end else if (kind == K_DEL_HEAD) begin
								rd_q <= (CW+1)'(1);
								wr_q <= '0;
								state_q <= S_DEL;
							end else begin
								rd_q <= '0;
								wr_q <= '0;
								state_q <= S_CMP;
							end
						end else if (kind == K_CLEAR) begin
							used_q <= '0;
							cnt_q <= '0;
						end
					end
				end
				S_INS: begin
					// new-value write at ins_idx ends the shift
					if (!rvalid_q && (rd_q[CW] || rd_q[CW-1:0] < CW'(ins_idx_q) ||
						rd_q == '1)) begin
						if (CW'(ins_idx_q) == used_q) last_q <= val_q;
						used_q <= used_q + 1'b1;
						cnt_q <= used_q + 1'b1;
						state_q <= S_OUT;
					end else if (rvalid_q) begin
						if (wr_q == (CW+1)'(used_q)) last_q <= rdata;
						wr_q <= wr_q - 1'b1;
						rvalid_q <= 1'b0;
						if (rd_q[CW-1:0] < CW'(ins_idx_q))
							rd_q <= '1;
					end else begin
						rvalid_q <= 1'b1;
						rd_q <= rd_q - 1'b1;
					end
				end
				S_DEL: begin
					if (rvalid_q) begin
						rvalid_q <= 1'b0;
						last_q <= rdata;
						wr_q <= wr_q + 1'b1;
						if (wr_q == '1 || rd_q >= (CW+1)'(used_q)) begin
							if (wr_q != '1) begin
								used_q <= used_q - 1'b1;
								cnt_q <= used_q - 1'b1;
							end
							state_q <= S_OUT;
						end
					end else if (wr_q != '1 && rd_q >= (CW+1)'(used_q)) begin
						used_q <= used_q - 1'b1;
						cnt_q <= used_q - 1'b1;
						state_q <= S_OUT;
					end else begin
						rvalid_q <= 1'b1;
						rd_q <= rd_q + 1'b1;
					end
				end
				S_CMP: begin
					if (rvalid_q) begin
						rvalid_q <= 1'b0;
						if (rdata != val_q) begin
							last_q <= rdata;
							wr_q <= wr_q + 1'b1;
						end
					end else if (rd_q >= (CW+1)'(used_q)) begin
						used_q <= CW'(wr_q);
						cnt_q <= CW'(wr_q);
						if (wr_q == (CW+1)'(used_q)) st_q <= ST_NOTFOUND;
						state_q <= S_OUT;
					end else begin
						rvalid_q <= 1'b1;
						rd_q <= rd_q + 1'b1;
					end
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_count_range;
		@(posedge clk) disable iff (!arst_n) used_q <= CW'(DEPTH);
	endproperty
	a_count_range: assert property (p_count_range) else $error("count beyond depth");

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != S_IDLE) |-> !in_ready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

	property p_full_keeps;
		@(posedge clk) disable iff (!arst_n)
			(out_valid && status == ST_FULL) |-> (count == 7'(DEPTH));
	endproperty
	a_full_keeps: assert property (p_full_keeps) else $error("full status with room");
endmodule
